FILE: hw/rtl/point_cloud_angle_binner_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the point cloud angle binner
// Short property forms shared by the checker.
// ----------------------------------------------------------------------------
`ifndef POINT_CLOUD_ANGLE_BINNER_TOP_DEFINES_SVH
`define POINT_CLOUD_ANGLE_BINNER_TOP_DEFINES_SVH

// implication checked on every clock edge outside reset
`define PCAB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pcab check failed");

// next-cycle implication checked outside reset
`define PCAB_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pcab check failed");

`endif

FILE: hw/rtl/pcab_pkg.sv
// ----------------------------------------------------------------------------
// pcab_pkg
// Types, constants and CORDIC tables of the point cloud angle binner.
// ----------------------------------------------------------------------------
package pcab_pkg;

  localparam int unsigned MaxPoints = 4096;
  localparam int unsigned NumBins   = 512;
  localparam int unsigned PtAw      = $clog2(MaxPoints);
  localparam int unsigned PtCw      = PtAw + 1;
  localparam int unsigned BinAw     = $clog2(NumBins);
  localparam int unsigned BinCw     = BinAw + 1;
  localparam int unsigned Iters     = 16;
  localparam int unsigned CordW     = 34;
  localparam int unsigned QDepth    = 4;

  localparam logic [16:0] RangeOnes = 17'h1FFFF;
  localparam logic [31:0] GainInv   = 32'h26DD3B6A;

  typedef enum logic [1:0] {
    ActAdd    = 2'd0,
    ActFinish = 2'd1,
    ActRead   = 2'd2,
    ActNone   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    RegStep  = 2'd0,
    RegLower = 2'd1,
    RegUpper = 2'd2
  } reg_e;

  // command from front to back
  typedef struct packed {
    action_e            act;
    logic signed [17:0] x;
    logic signed [17:0] y;
    logic [BinAw-1:0]   idx;
  } cmd_t;

  function automatic logic [31:0] atan_lut(input logic [3:0] i);
    logic [31:0] r;
    case (i)
      4'd0:  r = 32'd536870912;
      4'd1:  r = 32'd316933406;
      4'd2:  r = 32'd167458907;
      4'd3:  r = 32'd85004756;
      4'd4:  r = 32'd42667331;
      4'd5:  r = 32'd21354465;
      4'd6:  r = 32'd10679838;
      4'd7:  r = 32'd5340245;
      4'd8:  r = 32'd2670163;
      4'd9:  r = 32'd1335087;
      4'd10: r = 32'd667544;
      4'd11: r = 32'd333772;
      4'd12: r = 32'd166886;
      4'd13: r = 32'd83443;
      4'd14: r = 32'd41722;
      default: r = 32'd20861;
    endcase
    return r;
  endfunction

endpackage

FILE: hw/rtl/pcab_front.sv
// ----------------------------------------------------------------------------
// pcab_front
// Input side: accepts items, drops unused actions, queues commands.
// ----------------------------------------------------------------------------
module pcab_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  output logic                full_o,
  input  logic [1:0]          action_i,
  input  logic signed [17:0]  point_x_i,
  input  logic signed [17:0]  point_y_i,
  input  logic [8:0]          bin_index_i,
  output logic                cmd_valid_o,
  output pcab_pkg::cmd_t      cmd_o,
  input  logic                cmd_take_i
);
  import pcab_pkg::*;

  localparam int unsigned QAw = $clog2(QDepth);

  cmd_t           q_mem [QDepth];
  logic [QAw-1:0] wr_q, rd_q;
  logic [QAw:0]   cnt_q;
  logic           wr_en, rd_en;
  cmd_t           c;

  assign full_o = (cnt_q == (QAw+1)'(QDepth));
  assign c      = {action_i, point_x_i, point_y_i, bin_index_i};
  assign wr_en  = push_i && !full_o && (action_e'(action_i) != ActNone);
  assign rd_en  = cmd_take_i && cmd_valid_o;
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o  = q_mem[rd_q];

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      q_mem[wr_q] <= c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (wr_en) wr_q <= wr_q + 1'b1;
      if (rd_en) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (QAw+1)'(wr_en) - (QAw+1)'(rd_en);
    end
  end

endmodule

FILE: hw/rtl/pcab_cordic.sv
// ----------------------------------------------------------------------------
// pcab_cordic
// Iterative CORDIC vectoring: one rotation per cycle, then a range scale.
// ----------------------------------------------------------------------------
module pcab_cordic (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [17:0] x_i,
  input  logic signed [17:0] y_i,
  output logic               done_o,
  output logic signed [15:0] angle_o,
  output logic [16:0]        range_o
);
  import pcab_pkg::*;

  typedef enum logic [3:0] {
    CIdle = 4'b0001,
    CRot  = 4'b0010,
    CMul  = 4'b0100,
    CDone = 4'b1000
  } cst_e;

  cst_e                   st_q, st_d;
  logic signed [CordW-1:0] x_q, y_q, xs, ys;
  logic [31:0]            acc_q, acc_rnd;
  logic [3:0]             it_q;
  logic                   zero_q;
  logic [65:0]            prod_q;
  logic [23:0]            r_full;
  logic signed [CordW-1:0] x0, y0;

  assign x0 = CordW'(x_i) <<< 12;
  assign y0 = CordW'(y_i) <<< 12;
  assign xs = x_q >>> it_q;
  assign ys = y_q >>> it_q;
  assign acc_rnd = acc_q + 32'h8000;
  assign r_full  = 24'((prod_q + (66'd1 << 41)) >> 42);

  always_comb begin
    st_d = st_q;
    case (st_q)
      CIdle: if (start_i) st_d = CRot;
      CRot:  if (it_q == 4'(Iters-1)) st_d = CMul;
      CMul:  st_d = CDone;
      CDone: st_d = CIdle;
      default: st_d = CIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= CIdle;
    end else begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      CIdle: begin
        it_q   <= '0;
        zero_q <= (x_i == '0) && (y_i == '0);
        if (x_i < 0) begin
          x_q <= -x0; y_q <= -y0; acc_q <= 32'h8000_0000;
        end else begin
          x_q <= x0;  y_q <= y0;  acc_q <= '0;
        end
      end
      CRot: begin
        it_q <= it_q + 1'b1;
        if (!y_q[CordW-1]) begin
          x_q <= x_q + ys; y_q <= y_q - xs; acc_q <= acc_q + atan_lut(it_q);
        end else begin
          x_q <= x_q - ys; y_q <= y_q + xs; acc_q <= acc_q - atan_lut(it_q);
        end
      end
      CMul: prod_q <= 66'(x_q[31:0]) * 66'(GainInv);
      default: ;
    endcase
  end

  assign done_o  = (st_q == CDone);
  assign angle_o = zero_q ? '0 : acc_rnd[31:16];
  assign range_o = zero_q ? '0 : ((r_full > 24'(RangeOnes)) ? RangeOnes : r_full[16:0]);

endmodule

FILE: hw/rtl/pcab_back.sv
// ----------------------------------------------------------------------------
// pcab_back
// Executes commands: point store, finish sweep with bin clearing, bin reads.
// ----------------------------------------------------------------------------
module pcab_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  input  pcab_pkg::cmd_t     cmd_i,
  output logic               cmd_take_o,
  input  logic [14:0]        angle_step_i,
  input  logic [16:0]        range_lower_i,
  input  logic [16:0]        range_upper_i,
  output logic               empty_o,
  input  logic               pop_i,
  output logic signed [15:0] angle_low_o,
  output logic signed [15:0] angle_high_o,
  output logic [9:0]         bin_total_o,
  output logic [16:0]        bin_range_o,
  output logic               bin_hit_o,
  output logic               overflow_o
);
  import pcab_pkg::*;

  typedef enum logic [10:0] {
    SIdle  = 11'b00000000001,
    SCord  = 11'b00000000010,
    SDiv   = 11'b00000000100,
    SClr   = 11'b00000001000,
    SRdPt  = 11'b00000010000,
    SPtDiv = 11'b00000100000,
    SBinRd = 11'b00001000000,
    SBinWr = 11'b00010000000,
    SRdBin = 11'b00100000000,
    SRdOut = 11'b01000000000,
    SFinOut = 11'b10000000000
  } st_e;

  st_e st_q, st_d;

  logic [15:0] pa_mem [MaxPoints];
  logic [16:0] pr_mem [MaxPoints];
  logic [17:0] bin_mem [NumBins];

  logic [PtCw-1:0]  ptot_q, pi_q;
  logic signed [15:0] amin_q, amax_q;
  logic [BinCw-1:0] bins_q;
  logic             open_q, ovf_q;
  logic [BinAw-1:0] ci_q;
  cmd_t             cmd_q;

  logic             c_start, c_done;
  logic signed [15:0] c_ang;
  logic [16:0]      c_rng;

  logic [15:0] pa_rd_q;
  logic [16:0] pr_rd_q;
  logic [17:0] bin_rd_q;

  logic [14:0] step;
  logic [15:0] num_q, quo_q;
  logic [30:0] rem_q;
  logic [4:0]  dcnt_q;
  logic [30:0] trial;
  logic [BinAw-1:0] idx_q;

  logic        out_v_q;
  logic [16:0] o_rng_q;
  logic        o_hit_q;
  logic        out_free;

  assign step     = (angle_step_i == '0) ? 15'd1 : angle_step_i;
  assign out_free = !out_v_q || pop_i;
  assign empty_o  = !out_v_q;
  assign trial    = {rem_q[29:0], num_q[15]};

  assign cmd_take_o = (st_q == SIdle) && cmd_valid_i;
  assign c_start    = (st_q == SCord) && !c_done;

  pcab_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (c_start),
    .x_i     (cmd_q.x),
    .y_i     (cmd_q.y),
    .done_o  (c_done),
    .angle_o (c_ang),
    .range_o (c_rng)
  );

  always_comb begin
    st_d = st_q;
    case (st_q)
      SIdle: if (cmd_valid_i) begin
        case (cmd_i.act)
          ActAdd: begin
            if (open_q && ptot_q == PtCw'(MaxPoints)) st_d = SIdle;
            else st_d = SCord;
          end
          ActFinish: st_d = SClr;
          ActRead:   st_d = SRdBin;
          default:   st_d = SIdle;
        endcase
      end
      SCord:  if (c_done) st_d = SIdle;
      SClr:   if (ci_q == BinAw'(NumBins-1))
                st_d = (ptot_q == '0) ? SFinOut : SDiv;
      SDiv:   if (dcnt_q == 5'd16) st_d = SRdPt;
      SRdPt:  st_d = (pi_q == ptot_q) ? SFinOut : SPtDiv;
      SPtDiv: if (dcnt_q == 5'd17) st_d = SBinRd;
      SBinRd: st_d = SBinWr;
      SBinWr: st_d = SRdPt;
      SRdBin: st_d = SRdOut;
      SRdOut: if (out_free) st_d = SIdle;
      SFinOut: if (out_free) st_d = SIdle;
      default: st_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= SIdle;
      ptot_q  <= '0;
      amin_q  <= 16'sh7FFF;
      amax_q  <= 16'sh8000;
      bins_q  <= '0;
      open_q  <= 1'b0;
      ovf_q   <= 1'b0;
      out_v_q <= 1'b0;
      ci_q    <= '0;
      pi_q    <= '0;
      dcnt_q  <= '0;
    end else begin
      st_q <= st_d;
      out_v_q <= ((st_q == SRdOut || st_q == SFinOut) && out_free) || (out_v_q && !pop_i);
      case (st_q)
        SIdle: begin
          ci_q   <= '0;
          dcnt_q <= '0;
          if (cmd_valid_i && cmd_i.act == ActAdd) begin
            if (!open_q) begin
              ptot_q <= '0;
              amin_q <= 16'sh7FFF;
              amax_q <= 16'sh8000;
              ovf_q  <= 1'b0;
              open_q <= 1'b1;
            end else if (ptot_q == PtCw'(MaxPoints)) begin
              ovf_q <= 1'b1;
            end
          end
        end
        SCord: if (c_done) begin
          ptot_q <= ptot_q + 1'b1;
          if (c_ang < amin_q) amin_q <= c_ang;
          if (c_ang > amax_q) amax_q <= c_ang;
        end
        SClr: begin
          ci_q   <= ci_q + 1'b1;
          open_q <= 1'b0;
          pi_q   <= '0;
          if (ptot_q == '0) bins_q <= '0;
        end
        SDiv: begin
          if (dcnt_q == 5'd16) begin
            dcnt_q <= '0;
            if (quo_q >= 16'(NumBins)) begin
              bins_q <= BinCw'(NumBins);
              ovf_q  <= 1'b1;
            end else begin
              bins_q <= BinCw'(quo_q) + 1'b1;
            end
          end else begin
            dcnt_q <= dcnt_q + 1'b1;
          end
        end
        SPtDiv: begin
          if (dcnt_q == 5'd17) dcnt_q <= '0;
          else dcnt_q <= dcnt_q + 1'b1;
        end
        SBinWr: pi_q <= pi_q + 1'b1;
        default: ;
      endcase
    end
  end

  // restoring divider, one quotient bit per cycle
  always_ff @(posedge clk_i) begin
    if (st_q == SIdle && cmd_valid_i) cmd_q <= cmd_i;
    if (st_q == SClr) begin
      num_q <= 16'(amax_q - amin_q);
      rem_q <= '0;
      quo_q <= '0;
    end else if (st_q == SRdPt) begin
      rem_q <= '0;
      quo_q <= '0;
    end else if (st_q == SPtDiv && dcnt_q == 5'd0) begin
      num_q <= 16'(pa_rd_q - amin_q);
    end else if ((st_q == SDiv && dcnt_q != 5'd16) ||
                 (st_q == SPtDiv && dcnt_q != 5'd17)) begin
      num_q <= {num_q[14:0], 1'b0};
      if (trial >= 31'(step)) begin
        rem_q <= trial - 31'(step);
        quo_q <= {quo_q[14:0], 1'b1};
      end else begin
        rem_q <= trial;
        quo_q <= {quo_q[14:0], 1'b0};
      end
    end
    if (st_q == SPtDiv && dcnt_q == 5'd17) idx_q <= quo_q[BinAw-1:0];
  end

  // point store
  always_ff @(posedge clk_i) begin
    if (st_q == SCord && c_done) begin
      pa_mem[ptot_q[PtAw-1:0]] <= c_ang;
      pr_mem[ptot_q[PtAw-1:0]] <= c_rng;
    end
    pa_rd_q <= pa_mem[pi_q[PtAw-1:0]];
    pr_rd_q <= pr_mem[pi_q[PtAw-1:0]];
  end

  logic in_lim_q;
  logic [15:0] idx_full_q;

  // bin store, bit 17 marks a hit
  always_ff @(posedge clk_i) begin
    if (st_q == SPtDiv && dcnt_q == 5'd17) begin
      in_lim_q   <= (pr_rd_q >= range_lower_i) && (pr_rd_q <= range_upper_i);
      idx_full_q <= quo_q;
    end
    if (st_q == SClr) begin
      bin_mem[ci_q] <= {1'b0, RangeOnes};
    end else if (st_q == SBinWr && in_lim_q &&
                 ((BinCw+6)'(idx_full_q) < (BinCw+6)'(bins_q)) &&
                 ((bin_rd_q[17] && pr_rd_q < bin_rd_q[16:0]) ||
                  (!bin_rd_q[17] && {1'b0, pr_rd_q} < {1'b0, bin_rd_q[16:0]} + 18'd1))) begin
      bin_mem[idx_q] <= {1'b1, pr_rd_q};
    end
    if (st_q == SRdBin || st_q == SRdOut) bin_rd_q <= bin_mem[cmd_q.idx];
    else bin_rd_q <= bin_mem[idx_q];
  end

  always_ff @(posedge clk_i) begin
    if (st_q == SRdOut && out_free) begin
      if ((BinCw+1)'(cmd_q.idx) < (BinCw+1)'(bins_q)) begin
        o_rng_q <= bin_rd_q[16:0];
        o_hit_q <= bin_rd_q[17];
      end else begin
        o_rng_q <= RangeOnes;
        o_hit_q <= 1'b0;
      end
    end else if (st_q == SFinOut && out_free) begin
      o_rng_q <= RangeOnes;
      o_hit_q <= 1'b0;
    end
  end

  logic signed [15:0] ol_q, oh_q;
  logic [9:0]         ot_q;
  logic               oo_q;
  always_ff @(posedge clk_i) begin
    if ((st_q == SRdOut || st_q == SFinOut) && out_free) begin
      ol_q <= (ptot_q != '0) ? amin_q : '0;
      oh_q <= (ptot_q != '0) ? amax_q : '0;
      ot_q <= 10'(bins_q);
      oo_q <= ovf_q;
    end
  end

  assign angle_low_o  = ol_q;
  assign angle_high_o = oh_q;
  assign bin_total_o  = ot_q;
  assign bin_range_o  = o_rng_q;
  assign bin_hit_o    = o_hit_q;
  assign overflow_o   = oo_q;

endmodule

FILE: hw/rtl/point_cloud_angle_binner_top.sv
// ----------------------------------------------------------------------------
// point_cloud_angle_binner_top
// Point cloud to scan binner with queue-style ports and APB registers.
// ----------------------------------------------------------------------------
// An add runs the iterative 16-step CORDIC and its range scale. A read
// fetches the bin and then registers the output. A finish clears all 512
// bins, divides the angle span by the step to get the bin count, then
// handles each stored point with the serial divider that turns its angle into a bin index.
// Items queue in a four-entry command queue while earlier work runs.
module point_cloud_angle_binner_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic [1:0]         action_i,
  input  logic signed [17:0] point_x_i,
  input  logic signed [17:0] point_y_i,
  input  logic [8:0]         bin_index_i,
  output logic               empty,
  input  logic               pop,
  output logic signed [15:0] angle_low_o,
  output logic signed [15:0] angle_high_o,
  output logic [9:0]         bin_total_o,
  output logic [16:0]        bin_range_o,
  output logic               bin_hit_o,
  output logic               overflow_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import pcab_pkg::*;

  logic [14:0] step_q;
  logic [16:0] lower_q, upper_q;
  logic        cmd_valid, cmd_take;
  cmd_t        cmd;
  logic        wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= 15'd182;
      lower_q <= 17'd0;
      upper_q <= 17'd30000;
    end else if (wr) begin
      case (reg_e'(paddr[3:2]))
        RegStep:  step_q  <= pwdata[14:0];
        RegLower: lower_q <= pwdata[16:0];
        RegUpper: upper_q <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_e'(paddr[3:2]))
      RegStep:  prdata = {17'd0, step_q};
      RegLower: prdata = {15'd0, lower_q};
      RegUpper: prdata = {15'd0, upper_q};
      default:  prdata = '0;
    endcase
  end

  pcab_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .action_i    (action_i),
    .point_x_i   (point_x_i),
    .point_y_i   (point_y_i),
    .bin_index_i (bin_index_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_take_i  (cmd_take)
  );

  pcab_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (cmd_valid),
    .cmd_i         (cmd),
    .cmd_take_o    (cmd_take),
    .angle_step_i  (step_q),
    .range_lower_i (lower_q),
    .range_upper_i (upper_q),
    .empty_o       (empty),
    .pop_i         (pop),
    .angle_low_o   (angle_low_o),
    .angle_high_o  (angle_high_o),
    .bin_total_o   (bin_total_o),
    .bin_range_o   (bin_range_o),
    .bin_hit_o     (bin_hit_o),
    .overflow_o    (overflow_o)
  );

endmodule

FILE: hw/rtl/pcab_checker.sv
// ----------------------------------------------------------------------------
// pcab_checker
// Port-level checks of the binner, bound to the top level.
// ----------------------------------------------------------------------------
`include "point_cloud_angle_binner_top_defines.svh"

module pcab_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        empty,
  input logic        pop,
  input logic        pready,
  input logic [9:0]  bin_total_o,
  input logic [16:0] bin_range_o,
  input logic        bin_hit_o
);
  `PCAB_ASSERT_IMP(a_pready, clk_i, rst_ni, 1'b1, pready)
  `PCAB_ASSERT_NXT(a_hold, clk_i, rst_ni, !empty && !pop, !empty && $stable(bin_range_o))
  `PCAB_ASSERT_IMP(a_total, clk_i, rst_ni, !empty, bin_total_o <= 10'd512)
  `PCAB_ASSERT_IMP(a_miss, clk_i, rst_ni, !empty && !bin_hit_o, bin_range_o == 17'h1FFFF)
endmodule

bind point_cloud_angle_binner_top pcab_checker u_pcab_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .empty       (empty),
  .pop         (pop),
  .pready      (pready),
  .bin_total_o (bin_total_o),
  .bin_range_o (bin_range_o),
  .bin_hit_o   (bin_hit_o)
);
